// File: design/ssnf_pkg.sv
package ssnf_pkg;

    localparam int MagWidth   = 14;
    localparam int DigitWidth = 4;
    localparam int Latency    = 5;

    localparam logic [7:0] SEG_BLANK   = 8'hFF;
    localparam logic [7:0] SEG_MINUS   = 8'hBF;
    localparam logic [7:0] SEG_NINE_DP = 8'h10;
    localparam logic [7:0] SEG_DP_MASK = 8'h7F;

    localparam logic signed [15:0] DEC_MAX = 16'sd9999;
    localparam logic signed [15:0] DEC_MIN = -16'sd999;

    // exact floor(x / 10) for x below 2**16: (x * 52429) >> 19
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef enum logic [1:0] {
        MODE_DEC = 2'd0,
        MODE_HEX = 2'd1,
        MODE_OCT = 2'd2,
        MODE_BIN = 2'd3
    } t_mode;

    typedef struct packed {
        logic [15:0] raw;
        t_mode       mode;
        logic [2:0]  min_d;
        logic        neg;
        logic        ovf;
        logic        unf;
    } t_ctl;

    function automatic logic [7:0] glyph(input logic [3:0] code);
        logic [7:0] g;
        case (code)
            4'h0:    g = 8'hC0;
            4'h1:    g = 8'hF9;
            4'h2:    g = 8'hA4;
            4'h3:    g = 8'hB0;
            4'h4:    g = 8'h99;
            4'h5:    g = 8'h92;
            4'h6:    g = 8'h82;
            4'h7:    g = 8'hF8;
            4'h8:    g = 8'h80;
            4'h9:    g = 8'h90;
            4'hA:    g = 8'h88;
            4'hB:    g = 8'h83;
            4'hC:    g = 8'hC6;
            4'hD:    g = 8'hA1;
            4'hE:    g = 8'h86;
            default: g = 8'h8E;
        endcase
        return g;
    endfunction

endpackage

// File: design/ssnf_div10_stage.sv
module ssnf_div10_stage
    import ssnf_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  t_ctl                          i_ctl,
    input  logic [MagWidth-1:0]           i_quot,
    input  logic [3*DigitWidth-1:0]       i_digits,
    input  logic [2:0]                    i_nz,
    output logic                          o_valid,
    output t_ctl                          o_ctl,
    output logic [MagWidth-1:0]           o_quot,
    output logic [3*DigitWidth-1:0]       o_digits,
    output logic [2:0]                    o_nz
);

    logic [MagWidth+15:0]   prod;
    logic [MagWidth-1:0]    quot;
    logic [MagWidth-1:0]    rem_full;
    logic [DigitWidth-1:0]  rem;

    logic                        r_valid;
    t_ctl                        r_ctl;
    logic [MagWidth-1:0]         r_quot;
    logic [3*DigitWidth-1:0]     r_digits;
    logic [2:0]                  r_nz;

    always_comb begin
        prod     = {16'd0, i_quot} * {{MagWidth{1'b0}}, DIV10_MUL};
        quot     = MagWidth'(prod >> DIV10_SHIFT);
        rem_full = i_quot - ((quot << 3) + (quot << 1));
        rem      = rem_full[DigitWidth-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_ctl    <= i_ctl;
        r_quot   <= quot;
        r_digits <= {rem, i_digits[3*DigitWidth-1:DigitWidth]};
        r_nz     <= {quot != '0, i_nz[2:1]};
    end

    assign o_valid  = r_valid;
    assign o_ctl    = r_ctl;
    assign o_quot   = r_quot;
    assign o_digits = r_digits;
    assign o_nz     = r_nz;

endmodule

// File: design/ssnf_encode.sv
module ssnf_encode
    import ssnf_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  t_ctl                      i_ctl,
    input  logic [MagWidth-1:0]       i_quot,
    input  logic [3*DigitWidth-1:0]   i_digits,
    input  logic [2:0]                i_nz,
    output logic                      o_strobe,
    output logic [7:0]                o_seg0,
    output logic [7:0]                o_seg1,
    output logic [7:0]                o_seg2,
    output logic [7:0]                o_seg3
);

    logic [7:0] n_seg0;
    logic [7:0] n_seg1;
    logic [7:0] n_seg2;
    logic [7:0] n_seg3;
    logic [15:0] raw;

    logic       r_strobe;
    logic [7:0] r_seg0;
    logic [7:0] r_seg1;
    logic [7:0] r_seg2;
    logic [7:0] r_seg3;

    always_comb begin
        raw    = i_ctl.raw;
        n_seg0 = SEG_BLANK;
        n_seg1 = SEG_BLANK;
        n_seg2 = SEG_BLANK;
        n_seg3 = SEG_BLANK;
        case (i_ctl.mode)
            MODE_HEX: begin
                n_seg0 = glyph(raw[15:12]);
                n_seg1 = glyph(raw[11:8]);
                n_seg2 = glyph(raw[7:4]);
                n_seg3 = glyph(raw[3:0]);
            end
            MODE_OCT: begin
                n_seg0 = glyph({1'b0, raw[11:9]});
                n_seg1 = glyph({1'b0, raw[8:6]});
                n_seg2 = glyph({1'b0, raw[5:3]});
                n_seg3 = glyph({1'b0, raw[2:0]});
            end
            MODE_BIN: begin
                n_seg0 = glyph({3'b000, raw[3]});
                n_seg1 = glyph({3'b000, raw[2]});
                n_seg2 = glyph({3'b000, raw[1]});
                n_seg3 = glyph({3'b000, raw[0]});
            end
            default: begin
                if (i_ctl.ovf) begin
                    n_seg0 = SEG_NINE_DP;
                    n_seg1 = SEG_NINE_DP;
                    n_seg2 = SEG_NINE_DP;
                    n_seg3 = SEG_NINE_DP;
                end else if (i_ctl.unf) begin
                    n_seg0 = SEG_MINUS;
                    n_seg1 = SEG_NINE_DP;
                    n_seg2 = SEG_NINE_DP;
                    n_seg3 = SEG_NINE_DP;
                end else begin
                    n_seg3 = glyph(i_digits[3:0]) & SEG_DP_MASK;
                    if (i_nz[0]) begin
                        n_seg2 = glyph(i_digits[7:4]);
                    end else begin
                        n_seg2 = (i_ctl.min_d < 3'd2) ? SEG_BLANK : glyph(4'd0);
                    end
                    if (i_nz[1]) begin
                        n_seg1 = glyph(i_digits[11:8]);
                    end else begin
                        n_seg1 = (i_ctl.min_d < 3'd3) ? SEG_BLANK : glyph(4'd0);
                    end
                    if (i_ctl.neg) begin
                        n_seg0 = SEG_MINUS;
                    end else if (i_nz[2]) begin
                        n_seg0 = glyph(i_quot[DigitWidth-1:0]);
                    end else begin
                        n_seg0 = (i_ctl.min_d < 3'd4) ? SEG_BLANK : glyph(4'd0);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
        r_seg0 <= n_seg0;
        r_seg1 <= n_seg1;
        r_seg2 <= n_seg2;
        r_seg3 <= n_seg3;
    end

    assign o_strobe = r_strobe;
    assign o_seg0   = r_seg0;
    assign o_seg1   = r_seg1;
    assign o_seg2   = r_seg2;
    assign o_seg3   = r_seg3;

endmodule

// File: design/seven_segment_number_formatter.sv
// throughput: one item per cycle, busy is never raised
// stages: input/sign, three divide-by-ten stages, glyph encode
// synchronous active-low reset clears the valid pipeline; receiver cannot stall
module seven_segment_number_formatter
    import ssnf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_value,
    input  logic [1:0]  i_mode,
    input  logic [2:0]  i_min_digits,
    output logic        o_strobe,
    output logic [7:0]  o_seg_digit0,
    output logic [7:0]  o_seg_digit1,
    output logic [7:0]  o_seg_digit2,
    output logic [7:0]  o_seg_digit3
);

    logic signed [15:0]  sval;
    logic [15:0]         abs_val;
    t_ctl                n_ctl;

    logic                r_valid;
    t_ctl                r_ctl;
    logic [MagWidth-1:0] r_mag;

    logic                     a_valid, b_valid, c_valid;
    t_ctl                     a_ctl, b_ctl, c_ctl;
    logic [MagWidth-1:0]      a_quot, b_quot, c_quot;
    logic [3*DigitWidth-1:0]  a_digits, b_digits, c_digits;
    logic [2:0]               a_nz, b_nz, c_nz;

    assign busy = 1'b0;

    always_comb begin
        sval        = i_value;
        abs_val     = sval[15] ? (~i_value + 16'd1) : i_value;
        n_ctl.raw   = i_value;
        n_ctl.mode  = t_mode'(i_mode);
        n_ctl.min_d = i_min_digits;
        n_ctl.neg   = sval[15];
        n_ctl.ovf   = sval > DEC_MAX;
        n_ctl.unf   = sval < DEC_MIN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start && !busy;
        end
        r_ctl <= n_ctl;
        r_mag <= abs_val[MagWidth-1:0];
    end

    ssnf_div10_stage u_div_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_valid),
        .i_ctl    (r_ctl),
        .i_quot   (r_mag),
        .i_digits ('0),
        .i_nz     ('0),
        .o_valid  (a_valid),
        .o_ctl    (a_ctl),
        .o_quot   (a_quot),
        .o_digits (a_digits),
        .o_nz     (a_nz)
    );

    ssnf_div10_stage u_div_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (a_valid),
        .i_ctl    (a_ctl),
        .i_quot   (a_quot),
        .i_digits (a_digits),
        .i_nz     (a_nz),
        .o_valid  (b_valid),
        .o_ctl    (b_ctl),
        .o_quot   (b_quot),
        .o_digits (b_digits),
        .o_nz     (b_nz)
    );

    ssnf_div10_stage u_div_c (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (b_valid),
        .i_ctl    (b_ctl),
        .i_quot   (b_quot),
        .i_digits (b_digits),
        .i_nz     (b_nz),
        .o_valid  (c_valid),
        .o_ctl    (c_ctl),
        .o_quot   (c_quot),
        .o_digits (c_digits),
        .o_nz     (c_nz)
    );

    ssnf_encode u_encode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_valid),
        .i_ctl    (c_ctl),
        .i_quot   (c_quot),
        .i_digits (c_digits),
        .i_nz     (c_nz),
        .o_strobe (o_strobe),
        .o_seg0   (o_seg_digit0),
        .o_seg1   (o_seg_digit1),
        .o_seg2   (o_seg_digit2),
        .o_seg3   (o_seg_digit3)
    );

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##5 o_strobe)
        else $error("missing result strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##5 !o_strobe)
        else $error("unexpected result strobe");

    a_dec_dp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_mode == MODE_DEC) |-> ##5 !o_seg_digit3[7])
        else $error("decimal point not lit in decimal mode");

    a_other_dp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_mode != MODE_DEC) |-> ##5 o_seg_digit3[7])
        else $error("decimal point lit outside decimal mode");

endmodule

// File: dv/seven_segment_number_formatter_check.sv
module seven_segment_number_formatter_check
    import ssnf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [15:0] i_value,
    input  logic [1:0]  i_mode,
    input  logic [2:0]  i_min_digits,
    input  logic        i_strobe,
    input  logic [7:0]  i_seg_digit0,
    input  logic [7:0]  i_seg_digit1,
    input  logic [7:0]  i_seg_digit2,
    input  logic [7:0]  i_seg_digit3,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] DIGIT_GLYPH [16] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
        8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
    };

    typedef struct {
        logic [15:0] value;
        t_mode       mode;
        logic [2:0]  min_d;
        logic [7:0]  seg [4];
    } display_t;

    display_t expected_displays [$];
    int fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_displays.size();

    // one decimal digit left of the rightmost, blank or zero once the number runs out
    function automatic logic [7:0] leading_glyph(inout int unsigned rest,
                                                 input logic [2:0] min_d,
                                                 input int unsigned need);
        logic [7:0] g;
        if (rest != 0) begin
            g = DIGIT_GLYPH[rest % 10];
            rest = rest / 10;
        end else begin
            g = (min_d < need) ? SEG_BLANK : DIGIT_GLYPH[0];
        end
        return g;
    endfunction

    function automatic display_t format_display(logic [15:0] raw, t_mode mode,
                                                logic [2:0] min_d);
        display_t d;
        logic signed [15:0] v;
        int unsigned mag;
        logic neg;
        d.value = raw;
        d.mode  = mode;
        d.min_d = min_d;
        v = raw;
        case (mode)
            MODE_HEX: begin
                d.seg[0] = DIGIT_GLYPH[raw[15:12]];
                d.seg[1] = DIGIT_GLYPH[raw[11:8]];
                d.seg[2] = DIGIT_GLYPH[raw[7:4]];
                d.seg[3] = DIGIT_GLYPH[raw[3:0]];
            end
            MODE_OCT: begin
                d.seg[0] = DIGIT_GLYPH[{1'b0, raw[11:9]}];
                d.seg[1] = DIGIT_GLYPH[{1'b0, raw[8:6]}];
                d.seg[2] = DIGIT_GLYPH[{1'b0, raw[5:3]}];
                d.seg[3] = DIGIT_GLYPH[{1'b0, raw[2:0]}];
            end
            MODE_BIN: begin
                d.seg[0] = DIGIT_GLYPH[{3'b0, raw[3]}];
                d.seg[1] = DIGIT_GLYPH[{3'b0, raw[2]}];
                d.seg[2] = DIGIT_GLYPH[{3'b0, raw[1]}];
                d.seg[3] = DIGIT_GLYPH[{3'b0, raw[0]}];
            end
            default: begin
                if (v > DEC_MAX) begin
                    d.seg = '{SEG_NINE_DP, SEG_NINE_DP, SEG_NINE_DP, SEG_NINE_DP};
                end else if (v < DEC_MIN) begin
                    d.seg = '{SEG_MINUS, SEG_NINE_DP, SEG_NINE_DP, SEG_NINE_DP};
                end else begin
                    neg = v < 0;
                    mag = neg ? -int'(v) : int'(v);
                    d.seg[3] = DIGIT_GLYPH[mag % 10] & SEG_DP_MASK;
                    mag = mag / 10;
                    d.seg[2] = leading_glyph(mag, min_d, 2);
                    d.seg[1] = leading_glyph(mag, min_d, 3);
                    d.seg[0] = neg ? SEG_MINUS : leading_glyph(mag, min_d, 4);
                end
            end
        endcase
        return d;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        display_t exp_d;
        logic [7:0] got [4];
        if (i_rst_n) begin
            if (i_start && !i_busy)
                expected_displays.push_back(format_display(i_value, t_mode'(i_mode),
                                                           i_min_digits));
            if (i_strobe) begin
                got = '{i_seg_digit0, i_seg_digit1, i_seg_digit2, i_seg_digit3};
                if (expected_displays.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h %h %h %h",
                                              got[0], got[1], got[2], got[3]));
                end else begin
                    exp_d = expected_displays.pop_front();
                    for (int k = 0; k < 4; k++) begin
                        if (got[k] !== exp_d.seg[k])
                            report_mismatch($sformatf(
                                "value %h mode %s min %0d digit%0d got %h exp %h",
                                exp_d.value, exp_d.mode.name(), exp_d.min_d, k,
                                got[k], exp_d.seg[k]));
                    end
                end
            end
        end
    end

endmodule

// File: dv/seven_segment_number_formatter_test.sv
module seven_segment_number_formatter_test;
    import ssnf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomItems = 1900;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_value;
    logic [1:0]  i_mode;
    logic [2:0]  i_min_digits;
    logic        o_strobe;
    logic [7:0]  o_seg_digit0;
    logic [7:0]  o_seg_digit1;
    logic [7:0]  o_seg_digit2;
    logic [7:0]  o_seg_digit3;
    int          fail_count;
    int          pending;
    int          idle_pct;

    always #1 i_clk = ~i_clk;

    seven_segment_number_formatter i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .i_mode       (i_mode),
        .i_min_digits (i_min_digits),
        .o_strobe     (o_strobe),
        .o_seg_digit0 (o_seg_digit0),
        .o_seg_digit1 (o_seg_digit1),
        .o_seg_digit2 (o_seg_digit2),
        .o_seg_digit3 (o_seg_digit3)
    );

    seven_segment_number_formatter_check i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_value      (i_value),
        .i_mode       (i_mode),
        .i_min_digits (i_min_digits),
        .i_strobe     (o_strobe),
        .i_seg_digit0 (o_seg_digit0),
        .i_seg_digit1 (o_seg_digit1),
        .i_seg_digit2 (o_seg_digit2),
        .i_seg_digit3 (o_seg_digit3),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_number(logic [15:0] value, t_mode mode, logic [2:0] min_d);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_value      <= value;
        i_mode       <= mode;
        i_min_digits <= min_d;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
    endtask

    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(5))
            0, 1:    v = 16'($urandom);
            2:       v = 16'($urandom_range(10998) - 999);
            3:       v = 16'($urandom_range(99));
            4:       v = 16'($urandom_range(40) - 20);
            default: begin
                // around the decimal limits and the 16-bit signed limits
                case ($urandom_range(3))
                    0:       v = 16'(9999 + $urandom_range(4) - 2);
                    1:       v = 16'(-999 + $urandom_range(4) - 2);
                    2:       v = 16'(32767 - $urandom_range(3));
                    default: v = 16'(-32768 + $urandom_range(3));
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_value      <= '0;
        i_mode       <= MODE_DEC;
        i_min_digits <= '0;
        idle_pct     = 30;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: leading zeros, decimal limits, every glyph in hex and binary mode
        for (int m = 0; m <= 4; m++)
            send_number(16'd0, MODE_DEC, 3'(m));
        send_number(16'd9999, MODE_DEC, 3'd0);
        send_number(16'd10000, MODE_DEC, 3'd0);
        send_number(-16'sd999, MODE_DEC, 3'd0);
        send_number(-16'sd1000, MODE_DEC, 3'd0);
        send_number(16'h7FFF, MODE_DEC, 3'd7);
        send_number(16'h8000, MODE_DEC, 3'd0);
        send_number(-16'sd5, MODE_DEC, 3'd4);
        send_number(-16'sd5, MODE_DEC, 3'd0);
        send_number(16'd7, MODE_DEC, 3'd7);
        send_number(16'd123, MODE_DEC, 3'd3);
        send_number(16'd1203, MODE_DEC, 3'd5);
        send_number(16'h0123, MODE_HEX, 3'd0);
        send_number(16'h4567, MODE_HEX, 3'd2);
        send_number(16'h89AB, MODE_HEX, 3'd4);
        send_number(16'hCDEF, MODE_HEX, 3'd6);
        send_number(16'hFFFF, MODE_OCT, 3'd1);
        send_number(16'hF053, MODE_OCT, 3'd0);
        send_number(16'h000A, MODE_BIN, 3'd0);
        send_number(16'hFFF5, MODE_BIN, 3'd7);

        for (int n = 0; n < RandomItems; n++) begin
            if (n == RandomItems / 3)
                idle_pct = 84;
            else if (n == 2 * RandomItems / 3)
                idle_pct = 0;
            send_number(pick_value(), t_mode'($urandom_range(3)),
                        ($urandom_range(4) == 0) ? 3'($urandom_range(7))
                                                 : 3'($urandom_range(4)));
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (2 * Latency) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #1ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
